[rtl/fgno_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fgno_pkg
// Types, widths and constants shared by the film grain overlay blocks.
// ----------------------------------------------------------------------------
package fgno_pkg;

   localparam int COORD_BITS = 12;
   localparam int PIXEL_BITS = 16;

   localparam int IDX_W  = COORD_BITS + 8;
   localparam int POS_W  = COORD_BITS + 24;
   localparam int STEP_W = 24;
   localparam int SG_W   = 20;
   localparam int DLT_W  = PIXEL_BITS + 8;
   localparam int LAT    = 12;

   localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

   localparam logic [31:0] HASH_MUL_X = 32'd1619;
   localparam logic [31:0] HASH_MUL_Y = 32'd31337;
   localparam logic [31:0] HASH_MUL_S = 32'd6971;
   localparam logic [31:0] HASH_MUL_Q = 32'd15731;
   localparam logic [31:0] HASH_ADD_Q = 32'd789221;
   localparam logic [31:0] HASH_ADD_R = 32'd1376312589;

   localparam logic [15:0] SEED_XOR_G = 16'h4A3F;
   localparam logic [15:0] SEED_XOR_B = 16'h9C1E;

   localparam logic [15:0] MIX_COARSE = 16'd42598;
   localparam logic [15:0] MIX_FINE   = 16'd22938;
   localparam logic [15:0] LUMA_R     = 16'd13933;
   localparam logic [15:0] LUMA_G     = 16'd46871;
   localparam logic [15:0] LUMA_B     = 16'd4732;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COARSE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_R   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_G   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_B   = 3'd6;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [PIXEL_BITS-1:0] in_red;
      logic [PIXEL_BITS-1:0] in_green;
      logic [PIXEL_BITS-1:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] out_red;
      logic [PIXEL_BITS-1:0] out_green;
      logic [PIXEL_BITS-1:0] out_blue;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] value;
   } csr_type;

   // octave 0 is coarse, octave 1 is fine
   typedef struct packed {
      logic [1:0][IDX_W-1:0] ix;
      logic [1:0][IDX_W-1:0] iy;
   } lat_type;

   typedef struct packed {
      logic [1:0][15:0] sx;
      logic [1:0][15:0] sy;
   } fade_type;

endpackage
`default_nettype wire

[rtl/fgno_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fgno_if
// Valid/ready channels for pixel requests, responses and register writes.
// ----------------------------------------------------------------------------
interface fgno_req_if;
   logic              valid;
   logic              ready;
   fgno_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fgno_rsp_if;
   logic              valid;
   logic              ready;
   fgno_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fgno_csr_if;
   logic              valid;
   logic              ready;
   fgno_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/film_grain_noise_overlay_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// film_grain_noise_overlay_top
// Adds two-octave value-noise film grain to an RGB pixel stream.
// ----------------------------------------------------------------------------
// One pixel beat is taken every clock while the output is not stalled, and
// its response comes out behind the lattice position multiply, the fade, the
// four-stage multiplier chain of the hash and the blend and amplitude stages
// behind it. Three channel lanes run side by side and the output stage merges
// their grain into the saturated pixel. A stalled response holds the whole
// pipeline, so req_chan.ready follows rsp_chan.ready when the output is full.
// Register writes are taken every cycle and must be made with the block idle.
module film_grain_noise_overlay_top (
   input  wire logic clock,
   input  wire logic reset,
   fgno_req_if.sink   req_chan,
   fgno_rsp_if.source rsp_chan,
   fgno_csr_if.sink   csr_chan
);

   localparam int PixW = fgno_pkg::PIXEL_BITS;
   localparam int PosW = fgno_pkg::POS_W;
   localparam int IdxW = fgno_pkg::IDX_W;
   localparam int SgW  = fgno_pkg::SG_W;
   localparam int DltW = fgno_pkg::DLT_W;
   localparam int Lat  = fgno_pkg::LAT;
   localparam int LumW = PixW + 16;
   localparam int WtW  = 2 * PixW + 2;

   // register file
   logic [15:0] seed_ff, strength_ff;
   logic [23:0] coarse_ff, fine_ff;
   logic [2:0][15:0] gain_ff;
   logic [2:0][SgW-1:0] sg_in, sg_ff;
   logic [2:0][31:0] sg_prod;
   logic csr_acc;

   assign csr_chan.ready = 1'b1;
   assign csr_acc = csr_chan.valid & csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= '0;
         coarse_ff   <= 24'd65536;
         fine_ff     <= 24'd65536;
         strength_ff <= 16'd4096;
         gain_ff     <= {3{16'd4096}};
      end else if (csr_acc) begin
         unique case (csr_chan.data.index)
            fgno_pkg::CSR_SEED:     seed_ff     <= csr_chan.data.value[15:0];
            fgno_pkg::CSR_COARSE:   coarse_ff   <= csr_chan.data.value;
            fgno_pkg::CSR_FINE:     fine_ff     <= csr_chan.data.value;
            fgno_pkg::CSR_STRENGTH: strength_ff <= csr_chan.data.value[15:0];
            fgno_pkg::CSR_GAIN_R:   gain_ff[0]  <= csr_chan.data.value[15:0];
            fgno_pkg::CSR_GAIN_G:   gain_ff[1]  <= csr_chan.data.value[15:0];
            fgno_pkg::CSR_GAIN_B:   gain_ff[2]  <= csr_chan.data.value[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sg_prod[i] = 32'(strength_ff) * 32'(gain_ff[i]);
         sg_in[i]   = sg_prod[i][12 +: SgW];
      end
   end

   always_ff @(posedge clock) begin
      sg_ff <= sg_in;
   end

   // pipeline control
   logic           en, req_acc;
   logic [Lat:1]   vld_in, vld_ff;

   assign en     = !vld_ff[Lat] || rsp_chan.ready;
   assign req_acc = req_chan.valid & req_chan.ready;
   assign req_chan.ready = en;
   assign vld_in = {vld_ff[Lat-1:1], req_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // position, fade, luma and weight
   logic [1:0][1:0][PosW-1:0] pos_in, pos_ff;
   logic [1:0][1:0][15:0]     t2_in, t2_ff;
   logic [1:0][1:0][17:0]     tm_in, tm_ff;
   logic [1:0][1:0][31:0]     tsq;
   logic [1:0][1:0][33:0]     s_prod;
   logic [1:0][1:0][15:0]     s_in;
   logic [1:0][23:0]          step;
   fgno_pkg::lat_type         lat_in, lat_ff;
   fgno_pkg::fade_type        fade_in;
   fgno_pkg::fade_type        fade_ff [3:6];
   logic [LumW-1:0]           luma_sum;
   logic [PixW-1:0]           luma_in, luma_ff;
   logic [WtW-1:0]            wt_prod;
   logic [PixW-1:0]           weight_in;
   logic [PixW-1:0]           weight_ff [2:9];
   logic [2:0][PixW-1:0]      pix_in;
   logic [2:0][PixW-1:0]      pix_ff [1:11];

   always_comb begin
      step[0] = coarse_ff;
      step[1] = fine_ff;
      pix_in[0] = req_chan.data.in_red;
      pix_in[1] = req_chan.data.in_green;
      pix_in[2] = req_chan.data.in_blue;
      for (int o = 0; o < 2; o++) begin
         pos_in[o][0] = PosW'(req_chan.data.pixel_x) * PosW'(step[o]);
         pos_in[o][1] = PosW'(req_chan.data.pixel_y) * PosW'(step[o]);
         lat_in.ix[o] = pos_ff[o][0][16 +: IdxW];
         lat_in.iy[o] = pos_ff[o][1][16 +: IdxW];
         for (int d = 0; d < 2; d++) begin
            tsq[o][d]    = 32'(pos_ff[o][d][15:0]) * 32'(pos_ff[o][d][15:0]);
            t2_in[o][d]  = tsq[o][d][31:16];
            tm_in[o][d]  = 18'(19'd196608 - 19'({pos_ff[o][d][15:0], 1'b0}));
            s_prod[o][d] = 34'(t2_ff[o][d]) * 34'(tm_ff[o][d]);
            s_in[o][d]   = s_prod[o][d][31:16];
         end
         fade_in.sx[o] = s_in[o][0];
         fade_in.sy[o] = s_in[o][1];
      end
      luma_sum = LumW'(req_chan.data.in_red) * LumW'(fgno_pkg::LUMA_R)
               + LumW'(req_chan.data.in_green) * LumW'(fgno_pkg::LUMA_G)
               + LumW'(req_chan.data.in_blue) * LumW'(fgno_pkg::LUMA_B);
      luma_in  = luma_sum[16 +: PixW];
      wt_prod  = (WtW'(luma_ff) * WtW'(fgno_pkg::PIX_MAX - luma_ff)) << 2;
      weight_in = wt_prod[PixW +: PixW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff     <= pos_in;
         luma_ff    <= luma_in;
         lat_ff     <= lat_in;
         t2_ff      <= t2_in;
         tm_ff      <= tm_in;
         fade_ff[3] <= fade_in;
         for (int k = 4; k <= 6; k++) fade_ff[k] <= fade_ff[k-1];
         weight_ff[2] <= weight_in;
         for (int k = 3; k <= 9; k++) weight_ff[k] <= weight_ff[k-1];
         pix_ff[1] <= pix_in;
         for (int k = 2; k <= 11; k++) pix_ff[k] <= pix_ff[k-1];
      end
   end

   // channel lanes
   logic [2:0][15:0]      lane_seed;
   logic [2:0][DltW-1:0]  delta;
   logic [2:0]            neg;

   assign lane_seed[0] = seed_ff;
   assign lane_seed[1] = seed_ff ^ fgno_pkg::SEED_XOR_G;
   assign lane_seed[2] = seed_ff ^ fgno_pkg::SEED_XOR_B;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      fgno_lane u_lane (
         .clock  (clock),
         .en     (en),
         .lat    (lat_ff),
         .fade   (fade_ff[6]),
         .seed   (lane_seed[i]),
         .weight (weight_ff[9]),
         .sg     (sg_ff[i]),
         .delta  (delta[i]),
         .neg    (neg[i])
      );
   end

   // merge lanes into the saturated output beat
   logic [2:0][DltW:0]    sum;
   logic [2:0][PixW-1:0]  res;
   fgno_pkg::rsp_type     out_in, out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = (DltW+1)'(pix_ff[11][i]) + (DltW+1)'(delta[i]);
         if (neg[i]) begin
            res[i] = (DltW'(pix_ff[11][i]) > delta[i]) ?
                     PixW'(DltW'(pix_ff[11][i]) - delta[i]) : '0;
         end else begin
            res[i] = (sum[i] > (DltW+1)'(fgno_pkg::PIX_MAX)) ?
                     fgno_pkg::PIX_MAX : PixW'(sum[i]);
         end
      end
      out_in.out_red   = res[0];
      out_in.out_green = res[1];
      out_in.out_blue  = res[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid = vld_ff[Lat];
   assign rsp_chan.data  = out_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> vld_ff[1])
      else $error("accepted beat did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[Lat] && !rsp_chan.ready |=> $stable(vld_ff) && $stable(out_ff))
      else $error("pipeline moved while the response was stalled");

   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      csr_acc && csr_chan.data.index > fgno_pkg::CSR_GAIN_B |=>
      $stable(seed_ff) && $stable(coarse_ff) && $stable(fine_ff) &&
      $stable(strength_ff) && $stable(gain_ff))
      else $error("write to an unknown register changed the register file");

endmodule
`default_nettype wire

[rtl/fgno_hash.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fgno_hash
// Four-stage pipelined 32-bit lattice hash giving a Q0.16 noise value.
// ----------------------------------------------------------------------------
module fgno_hash (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] ix,
   input  wire logic [31:0] iy,
   input  wire logic [15:0] seed,
   output logic      [15:0] value
);

   logic [31:0] n0;
   logic [31:0] n_in, n1_ff, n2_ff, n3_ff;
   logic [31:0] sq_in, sq_ff;
   logic [31:0] p_in, p_ff;
   logic [31:0] v_in;
   logic [15:0] v_ff;

   always_comb begin
      n0    = ix * fgno_pkg::HASH_MUL_X + iy * fgno_pkg::HASH_MUL_Y
            + {16'b0, seed} * fgno_pkg::HASH_MUL_S;
      n_in  = n0 ^ (n0 << 13);
      sq_in = n1_ff * n1_ff;
      p_in  = sq_ff * fgno_pkg::HASH_MUL_Q + fgno_pkg::HASH_ADD_Q;
      v_in  = n3_ff * p_ff + fgno_pkg::HASH_ADD_R;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff <= n_in;
         sq_ff <= sq_in;
         n2_ff <= n1_ff;
         p_ff  <= p_in;
         n3_ff <= n2_ff;
         v_ff  <= v_in[30:15];
      end
   end

   assign value = v_ff;

endmodule
`default_nettype wire

[rtl/fgno_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fgno_lane
// One colour channel: two octaves of value noise, mix and grain amplitude.
// ----------------------------------------------------------------------------
module fgno_lane (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire fgno_pkg::lat_type                  lat,
   input  wire fgno_pkg::fade_type                 fade,
   input  wire logic [15:0]                        seed,
   input  wire logic [fgno_pkg::PIXEL_BITS-1:0]    weight,
   input  wire logic [fgno_pkg::SG_W-1:0]          sg,
   output logic      [fgno_pkg::DLT_W-1:0]         delta,
   output logic                                    neg
);

   localparam int PixW = fgno_pkg::PIXEL_BITS;
   localparam int SgW  = fgno_pkg::SG_W;
   localparam int DltW = fgno_pkg::DLT_W;

   logic [1:0][3:0][15:0] hv;

   for (genvar o = 0; o < 2; o++) begin : g_oct
      for (genvar c = 0; c < 4; c++) begin : g_corner
         logic [31:0] hx, hy;
         assign hx = 32'(lat.ix[o]) + 32'(c & 1);
         assign hy = 32'(lat.iy[o]) + 32'(c >> 1);
         fgno_hash u_hash (
            .clock (clock),
            .en    (en),
            .ix    (hx),
            .iy    (hy),
            .seed  (seed ^ 16'(o)),
            .value (hv[o][c])
         );
      end
   end

   logic [1:0][15:0] lo_in, lo_ff, hi_in, hi_ff, oct_in, oct_ff;
   logic [1:0][15:0] sy_ff;
   logic [1:0][33:0] lo_sum, hi_sum, oct_sum;
   logic [1:0][16:0] wx1, wx0, wy1, wy0;
   logic [32:0]      mix_sum;
   logic [16:0]      mixed;
   logic [15:0]      mag_in, mag_ff;
   logic             neg_in, neg9_ff, neg10_ff, neg11_ff;
   logic [PixW+15:0] m_prod;
   logic [PixW-1:0]  m_in, m_ff;
   logic [PixW+SgW-1:0] d_prod;
   logic [DltW-1:0]  d_in, d_ff;

   always_comb begin
      for (int o = 0; o < 2; o++) begin
         wx1[o]     = {1'b0, fade.sx[o]};
         wx0[o]     = 17'h10000 - wx1[o];
         lo_sum[o]  = 34'(hv[o][0]) * 34'(wx0[o]) + 34'(hv[o][1]) * 34'(wx1[o]);
         hi_sum[o]  = 34'(hv[o][2]) * 34'(wx0[o]) + 34'(hv[o][3]) * 34'(wx1[o]);
         lo_in[o]   = lo_sum[o][31:16];
         hi_in[o]   = hi_sum[o][31:16];
         wy1[o]     = {1'b0, sy_ff[o]};
         wy0[o]     = 17'h10000 - wy1[o];
         oct_sum[o] = 34'(lo_ff[o]) * 34'(wy0[o]) + 34'(hi_ff[o]) * 34'(wy1[o]);
         oct_in[o]  = oct_sum[o][31:16];
      end
      mix_sum = 33'(oct_ff[0]) * 33'(fgno_pkg::MIX_COARSE)
              + 33'(oct_ff[1]) * 33'(fgno_pkg::MIX_FINE);
      mixed   = 17'(mix_sum[32:16]);
      neg_in  = mixed < 17'd32768;
      mag_in  = neg_in ? 16'(17'd32768 - mixed) : 16'(mixed - 17'd32768);
      m_prod  = (PixW+16)'(mag_ff) * (PixW+16)'(weight);
      m_in    = m_prod[16 +: PixW];
      d_prod  = (PixW+SgW)'(m_ff) * (PixW+SgW)'(sg);
      d_in    = d_prod[12 +: DltW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sy_ff    <= fade.sy;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         oct_ff   <= oct_in;
         mag_ff   <= mag_in;
         neg9_ff  <= neg_in;
         m_ff     <= m_in;
         neg10_ff <= neg9_ff;
         d_ff     <= d_in;
         neg11_ff <= neg10_ff;
      end
   end

   assign delta = d_ff;
   assign neg   = neg11_ff;

endmodule
`default_nettype wire
